FILE: rtl/core/usan_pkg.sv
package usan_pkg;

  // byte classification masks
  localparam logic [7:0] ASCII_MASK = 8'h7F;
  localparam logic [7:0] CONT_MASK  = 8'hBF;
  localparam logic [7:0] LEAD2_MASK = 8'hDF;
  localparam logic [7:0] LEAD3_MASK = 8'hEF;
  localparam logic [7:0] LEAD4_MASK = 8'hF7;
  localparam logic [1:0] CONT_TAG   = 2'b10;

  localparam int unsigned MAX_CHAR = 4;
  localparam int unsigned HELD_MAX = MAX_CHAR - 1;

  // one queued group: a complete character and/or end of string
  typedef struct packed {
    logic [MAX_CHAR-1:0][7:0] bytes;
    logic [2:0]               count;
    logic                     last;
    logic                     valid;
  } usan_group_t;

  // lead length, 0 for a continuation or an illegal byte
  function automatic logic [2:0] lead_len(input logic [7:0] b);
    logic [2:0] len;
    if ((b & ASCII_MASK) == b) begin
      len = 3'd1;
    end else if ((b & CONT_MASK) == b) begin
      len = 3'd0;
    end else if ((b & LEAD2_MASK) == b) begin
      len = 3'd2;
    end else if ((b & LEAD3_MASK) == b) begin
      len = 3'd3;
    end else if ((b & LEAD4_MASK) == b) begin
      len = 3'd4;
    end else begin
      len = 3'd0;
    end
    return len;
  endfunction

endpackage

FILE: rtl/core/utf8_stream_sanitizer.sv
// UTF-8 stream sanitizer. Takes one string byte per request and passes on only
// the bytes of complete UTF-8 characters (ASCII, 2-, 3- and 4-byte leads with
// their 80-BF continuations); stray continuations, F8-FF and unfinished
// characters are dropped. A zero byte or in_last ends the string; the final
// result carries out_last and string_valid, which is 1 only if no byte of the
// string was dropped (an end marker with byte_present = 0 is sent when no byte
// goes out on that step). Input takes one byte per cycle while not stalled; the
// output gives one result per cycle while out_stall is low, one result for each
// byte of a character, drained from a QUEUE_DEPTH-entry group queue between
// classifier and output stage. Input stalls only while that queue is full. An
// accepted byte goes through the group queue and then the output register.
module utf8_stream_sanitizer #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       byte_present,
  output logic       out_last,
  output logic       string_valid
);
  import usan_pkg::*;

  usan_group_t push_group;
  usan_group_t head;
  logic        q_push;
  logic        q_pop;
  logic        q_full;
  logic        q_empty;

  // classifier and character assembly
  usan_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_byte  (in_byte),
    .in_last  (in_last),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_group  (push_group)
  );

  // group queue
  usan_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_group (push_group),
    .pop        (q_pop),
    .head       (head),
    .empty      (q_empty),
    .full       (q_full)
  );

  // byte serializer and output register
  usan_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (head),
    .q_empty      (q_empty),
    .q_pop        (q_pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_byte     (out_byte),
    .byte_present (byte_present),
    .out_last     (out_last),
    .string_valid (string_valid)
  );

endmodule

FILE: rtl/core/usan_front.sv
module usan_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [7:0]           in_byte,
  input  logic                 in_last,
  input  logic                 q_full,
  output logic                 q_push,
  output usan_pkg::usan_group_t q_group
);
  import usan_pkg::*;

  logic [HELD_MAX-1:0][7:0] held_bytes;
  logic [1:0] held_count, held_count_next;
  logic [2:0] char_length, char_length_next;
  logic       clean_so_far, clean_so_far_next;
  logic       hold_wr;
  logic [1:0] hold_idx;
  logic       accept;
  logic       last_eff;
  logic       is_cont;
  logic [2:0] len;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign is_cont  = (in_byte[7:6] == CONT_TAG);
  assign len      = lead_len(in_byte);

  // classify the incoming byte against the held character
  always_comb begin
    held_count_next   = held_count;
    char_length_next  = char_length;
    clean_so_far_next = clean_so_far;
    hold_wr           = 1'b0;
    hold_idx          = held_count;
    last_eff          = in_last;
    q_group.bytes     = {in_byte, held_bytes};
    q_group.count     = 3'd0;
    q_group.last      = 1'b0;
    q_group.valid     = 1'b0;

    if (in_byte == 8'd0) begin
      last_eff = 1'b1;
    end else if (held_count != 2'd0 && is_cont) begin
      if ({1'b0, held_count} + 3'd1 == char_length) begin
        q_group.bytes[held_count] = in_byte;
        q_group.count             = {1'b0, held_count} + 3'd1;
        held_count_next           = 2'd0;
        char_length_next          = 3'd0;
      end else begin
        hold_wr         = 1'b1;
        held_count_next = held_count + 2'd1;
      end
    end else begin
      if (held_count != 2'd0) begin
        held_count_next   = 2'd0;
        char_length_next  = 3'd0;
        clean_so_far_next = 1'b0;
      end
      if (len == 3'd0) begin
        clean_so_far_next = 1'b0;
      end else if (len == 3'd1) begin
        q_group.bytes[0] = in_byte;
        q_group.count    = 3'd1;
      end else begin
        hold_wr          = 1'b1;
        hold_idx         = 2'd0;
        held_count_next  = 2'd1;
        char_length_next = len;
      end
    end

    // end of string closes the group and restarts the state
    if (last_eff) begin
      if (held_count_next != 2'd0) begin
        clean_so_far_next = 1'b0;
      end
      q_group.last      = 1'b1;
      q_group.valid     = clean_so_far_next;
      held_count_next   = 2'd0;
      char_length_next  = 3'd0;
      clean_so_far_next = 1'b1;
    end
  end

  assign q_push = accept && (q_group.count != 3'd0 || last_eff);

  // character state
  always_ff @(posedge clk) begin
    if (rst) begin
      held_count   <= 2'd0;
      char_length  <= 3'd0;
      clean_so_far <= 1'b1;
    end else if (accept) begin
      held_count   <= held_count_next;
      char_length  <= char_length_next;
      clean_so_far <= clean_so_far_next;
    end
  end

  // held lead and continuation bytes
  always_ff @(posedge clk) begin
    if (accept && hold_wr) begin
      held_bytes[hold_idx] <= in_byte;
    end
  end

endmodule

FILE: rtl/core/usan_queue.sv
module usan_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  usan_pkg::usan_group_t push_group,
  input  logic                 pop,
  output usan_pkg::usan_group_t head,
  output logic                 empty,
  output logic                 full
);
  import usan_pkg::*;

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  usan_group_t         slots [DEPTH];
  logic [PW-1:0]       wr_ptr;
  logic [PW-1:0]       rd_ptr;
  logic [CW-1:0]       fill;
  logic                do_push;
  logic                do_pop;

  assign empty   = (fill == '0);
  assign full    = (fill == FULL_CNT);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = slots[rd_ptr];

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + PW'(1);
      end
      if (do_push && !do_pop) begin
        fill <= fill + CW'(1);
      end else if (do_pop && !do_push) begin
        fill <= fill - CW'(1);
      end
    end
  end

  // group storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_group;
    end
  end

endmodule

FILE: rtl/core/usan_back.sv
module usan_back (
  input  logic                 clk,
  input  logic                 rst,
  input  usan_pkg::usan_group_t head,
  input  logic                 q_empty,
  output logic                 q_pop,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [7:0]           out_byte,
  output logic                 byte_present,
  output logic                 out_last,
  output logic                 string_valid
);
  import usan_pkg::*;

  logic [1:0] idx;
  logic [1:0] last_idx;
  logic       is_final;
  logic       marker;
  logic       load;

  assign marker   = (head.count == 3'd0);
  assign last_idx = marker ? 2'd0 : 2'(head.count - 3'd1);
  assign is_final = (idx == last_idx);
  assign load     = !q_empty && (!out_valid || !out_stall);
  assign q_pop    = load && is_final;

  // walk through the bytes of the head group
  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= 2'd0;
    end else if (load) begin
      idx <= is_final ? 2'd0 : idx + 2'd1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte     <= marker ? 8'd0 : head.bytes[idx];
      byte_present <= !marker;
      out_last     <= is_final && head.last;
      string_valid <= is_final && head.last && head.valid;
    end
  end

endmodule

FILE: rtl/core/usan_checker.sv
module usan_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_byte,
  input logic       byte_present,
  input logic       out_last,
  input logic       string_valid
);

  // flag only rides on the final result of a string
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_last |-> !string_valid)
    else $error("string_valid set on a result that is not final");

  // an end marker is always the final result
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !byte_present |-> out_last)
    else $error("end marker without out_last");

  // an end marker carries a zero byte
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !byte_present |-> out_byte == 8'd0)
    else $error("end marker with nonzero byte");

  // a stalled result stays offered
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result withdrawn while stalled");

endmodule

bind utf8_stream_sanitizer usan_checker u_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .out_byte     (out_byte),
  .byte_present (byte_present),
  .out_last     (out_last),
  .string_valid (string_valid)
);

FILE: test/utf8_stream_checker.sv
module utf8_stream_checker (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic [7:0] out_byte,
  input  logic       byte_present,
  input  logic       out_last,
  input  logic       string_valid,
  output int         fail_count,
  output int         outstanding
);

  // byte ranges of the lead classes
  localparam logic [7:0] NUL_BYTE   = 8'h00;
  localparam logic [7:0] ASCII_TOP  = 8'h7F;
  localparam logic [7:0] CONT_TOP   = 8'hBF;
  localparam logic [7:0] LEAD2_TOP  = 8'hDF;
  localparam logic [7:0] LEAD3_TOP  = 8'hEF;
  localparam logic [7:0] LEAD4_TOP  = 8'hF7;
  localparam int         MAX_REPORT = 40;

  typedef struct packed {
    logic [7:0] data;
    logic       present;
    logic       last;
    logic       clean;
  } sanitized_t;

  // predictor state
  logic [7:0]  char_bytes [3];
  int          char_held;
  int          char_size;
  logic        string_clean;
  sanitized_t  sanitized_q [$];

  // expected character length for a lead byte, 0 when it cannot start one
  function automatic int lead_size(input logic [7:0] b);
    if (b <= ASCII_TOP) return 1;
    if (b <= CONT_TOP)  return 0;
    if (b <= LEAD2_TOP) return 2;
    if (b <= LEAD3_TOP) return 3;
    if (b <= LEAD4_TOP) return 4;
    return 0;
  endfunction

  task automatic push_byte(input logic [7:0] b, input logic present);
    sanitized_t r;
    r.data    = b;
    r.present = present;
    r.last    = 1'b0;
    r.clean   = 1'b0;
    sanitized_q.push_back(r);
  endtask

  // work out what one accepted request sends out
  task automatic sanitize_byte(input logic [7:0] b, input logic last);
    int         made;
    int         len;
    logic       ends;
    sanitized_t r;
    made = 0;
    ends = last || (b == NUL_BYTE);
    if (b == NUL_BYTE) begin
      // zero byte only ends the string
    end else if (char_held > 0 && b[7:6] == usan_pkg::CONT_TAG) begin
      if (char_held + 1 == char_size) begin
        for (int i = 0; i < char_held; i++) begin
          push_byte(char_bytes[i], 1'b1);
        end
        push_byte(b, 1'b1);
        made = char_held + 1;
        char_held = 0;
        char_size = 0;
      end else begin
        char_bytes[char_held] = b;
        char_held++;
      end
    end else begin
      // unfinished character gets dropped, the byte starts afresh
      if (char_held > 0) begin
        char_held = 0;
        char_size = 0;
        string_clean = 1'b0;
      end
      len = lead_size(b);
      if (len == 0) begin
        string_clean = 1'b0;
      end else if (len == 1) begin
        push_byte(b, 1'b1);
        made = 1;
      end else begin
        char_bytes[0] = b;
        char_held = 1;
        char_size = len;
      end
    end
    // end of string: flag the final result
    if (ends) begin
      if (char_held > 0) string_clean = 1'b0;
      if (made == 0) push_byte(NUL_BYTE, 1'b0);
      r = sanitized_q.pop_back();
      r.last  = 1'b1;
      r.clean = string_clean;
      sanitized_q.push_back(r);
      char_held = 0;
      char_size = 0;
      string_clean = 1'b1;
    end
  endtask

  task automatic report(input string msg);
    if (fail_count < MAX_REPORT) $display("MISMATCH at %0t: %s", $time, msg);
    fail_count++;
  endtask

  // compare results, then predict from new requests
  always @(posedge clk) begin
    sanitized_t want;
    if (rst) begin
      char_held = 0;
      char_size = 0;
      string_clean = 1'b1;
      fail_count = 0;
      sanitized_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (sanitized_q.size() == 0) begin
          report($sformatf("unexpected result byte %h present %b last %b valid %b",
                           out_byte, byte_present, out_last, string_valid));
        end else begin
          want = sanitized_q.pop_front();
          if (out_byte !== want.data)
            report($sformatf("out_byte %h, want %h", out_byte, want.data));
          if (byte_present !== want.present)
            report($sformatf("byte_present %b, want %b", byte_present, want.present));
          if (out_last !== want.last)
            report($sformatf("out_last %b, want %b", out_last, want.last));
          if (string_valid !== want.clean)
            report($sformatf("string_valid %b, want %b", string_valid, want.clean));
        end
      end
      if (in_valid && !in_stall) sanitize_byte(in_byte, in_last);
    end
    outstanding = sanitized_q.size();
  end

endmodule

FILE: test/testbench.sv
module testbench;

  localparam logic [7:0] NUL_BYTE      = 8'h00;
  localparam int         TX_ITEMS      = 180;
  localparam int         HOLD_AT       = 60;
  localparam int         HOLD_CYCLES   = 80;
  localparam int         STRETCH       = 40;
  localparam int         SETTLE_CYCLES = 8;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_byte = 8'h00;
  logic       in_last = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_byte;
  logic       byte_present;
  logic       out_last;
  logic       string_valid;
  int         fail_count;
  int         outstanding;

  logic       tx_idle = 1'b1;
  int         tx_sent = 0;
  int         rx_taken = 0;

  utf8_stream_sanitizer i_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_byte      (in_byte),
    .in_last      (in_last),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_byte     (out_byte),
    .byte_present (byte_present),
    .out_last     (out_last),
    .string_valid (string_valid)
  );

  utf8_stream_checker i_checker (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_byte      (in_byte),
    .in_last      (in_last),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_byte     (out_byte),
    .byte_present (byte_present),
    .out_last     (out_last),
    .string_valid (string_valid),
    .fail_count   (fail_count),
    .outstanding  (outstanding)
  );

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // run limit
  initial begin
    #2000000;
    $display("utf8_stream_sanitizer verification failed");
    $finish;
  end

  // one request, with a random gap ahead of it when tx_idle is set
  task automatic send_byte(input logic [7:0] b, input logic l);
    int gap;
    gap = tx_idle ? $urandom_range(0, 7) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    in_last  <= l;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    tx_sent++;
  endtask

  // stop offering until every result has come back
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    wait (outstanding == 0);
  endtask

  function automatic logic [7:0] cont_byte();
    return 8'h80 | 8'($urandom_range(0, 63));
  endfunction

  // append one character, well formed or a broken one
  task automatic add_char(inout logic [7:0] str_q [$], input logic broken);
    int kind;
    int conts;
    kind = $urandom_range(1, 4);
    if (broken) begin
      case ($urandom_range(0, 3))
        0: str_q.push_back(8'($urandom_range(1, 255)));
        1: str_q.push_back(cont_byte());
        2: str_q.push_back(8'($urandom_range(8'hF8, 8'hFF)));
        default: begin
          // character cut short
          kind = $urandom_range(2, 4);
          conts = $urandom_range(0, kind - 2);
          if (kind == 2) str_q.push_back(8'($urandom_range(8'hC0, 8'hDF)));
          else if (kind == 3) str_q.push_back(8'($urandom_range(8'hE0, 8'hEF)));
          else str_q.push_back(8'($urandom_range(8'hF0, 8'hF7)));
          repeat (conts) str_q.push_back(cont_byte());
        end
      endcase
    end else begin
      case (kind)
        1: str_q.push_back(8'($urandom_range(1, 127)));
        2: str_q.push_back(8'($urandom_range(8'hC0, 8'hDF)));
        3: str_q.push_back(8'($urandom_range(8'hE0, 8'hEF)));
        default: str_q.push_back(8'($urandom_range(8'hF0, 8'hF7)));
      endcase
      repeat (kind - 1) str_q.push_back(cont_byte());
    end
  endtask

  // random string: mostly clean, some with broken characters
  task automatic send_string();
    logic [7:0] str_q [$];
    logic       noisy;
    int         chars;
    noisy = ($urandom_range(0, 3) == 0);
    chars = $urandom_range(1, 6);
    repeat (chars) add_char(str_q, noisy && ($urandom_range(0, 2) == 0));
    if ($urandom_range(0, 4) == 0) str_q.push_back(NUL_BYTE);
    tx_idle = ($urandom_range(0, 3) != 0);
    foreach (str_q[i]) begin
      if (i == str_q.size() - 1) begin
        send_byte(str_q[i], (str_q[i] == NUL_BYTE) ? 1'($urandom_range(0, 1)) : 1'b1);
      end else begin
        send_byte(str_q[i], 1'($urandom_range(0, 7) == 0) && 1'b0);
      end
    end
  endtask

  // result side: random stalls, quiet stretches, one long hold
  initial begin
    int n;
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall) begin
        rx_taken++;
        if (rx_taken == HOLD_AT) n = HOLD_CYCLES;
        else if ((rx_taken / STRETCH) % 3 == 2) n = 0;
        else n = $urandom_range(0, 7);
        if (n > 0) begin
          out_stall <= 1'b1;
          repeat (n) @(posedge clk);
          out_stall <= 1'b0;
        end
      end
    end
  end

  // stimulus and verdict
  initial begin
    logic paused;
    paused = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed strings
    send_byte(8'h00, 1'b0);                                    // empty string
    send_byte(8'h7F, 1'b1);                                    // top ascii
    send_byte(8'hC2, 1'b0); send_byte(8'h80, 1'b1);            // two bytes
    send_byte(8'hE0, 1'b0); send_byte(8'hBF, 1'b0); send_byte(8'hBF, 1'b1);
    send_byte(8'hF7, 1'b0); send_byte(8'hBF, 1'b0);            // four bytes, then ascii
    send_byte(8'h80, 1'b0); send_byte(8'h80, 1'b0); send_byte(8'h01, 1'b1);
    send_byte(8'h80, 1'b1);                                    // stray continuation
    send_byte(8'hFF, 1'b0); send_byte(8'hF8, 1'b1);            // illegal leads
    send_byte(8'hDF, 1'b0); send_byte(8'h41, 1'b1);            // lead cut by ascii
    send_byte(8'hEF, 1'b0); send_byte(8'h80, 1'b0);            // zero byte with bytes held
    send_byte(8'h00, 1'b1);
    send_byte(8'hF0, 1'b0); send_byte(8'h90, 1'b1);            // string ends mid character
    drain();

    // random strings
    while (tx_sent < TX_ITEMS) begin
      send_string();
      if (!paused && tx_sent > TX_ITEMS / 2) begin
        paused = 1'b1;
        drain();
      end
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("utf8_stream_sanitizer verification clean");
    end else begin
      $display("utf8_stream_sanitizer verification failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/core/usan_pkg.sv
rtl/core/usan_front.sv
rtl/core/usan_queue.sv
rtl/core/usan_back.sv
rtl/core/utf8_stream_sanitizer.sv
rtl/core/usan_checker.sv
test/utf8_stream_checker.sv
test/testbench.sv
